FILE: rtl/vpr_pkg.sv
// Shared types, widths and tables of the visibility phase rotator.
package vpr_pkg;

    localparam int PW = 51;           // path in Q16 mm
    localparam int MW = 61;           // path times 1000
    localparam int AW = 60;           // magnitude of the phase numerator
    localparam int DW = 42;           // wavelength in Q16 um
    localparam int ZW = 34;           // CORDIC angle, 2^-32 turn
    localparam int CORDIC_ITERS = 24;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    typedef enum logic [2:0] {
        REG_SHIFT_BACK = 3'd0,
        REG_SIGN_FLIP  = 3'd1,
        REG_BYPASS     = 3'd2,
        REG_OFFSET_L   = 3'd3,
        REG_OFFSET_M   = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic               vld;
        logic               byp;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 34'h020000000;
            1:       a = 34'h012E4051E;
            2:       a = 34'h009FB385B;
            3:       a = 34'h0051111D4;
            4:       a = 34'h0028B0D43;
            5:       a = 34'h00145D7E1;
            6:       a = 34'h000A2F61E;
            7:       a = 34'h000517C55;
            8:       a = 34'h00028BE53;
            9:       a = 34'h000145F2F;
            10:      a = 34'h0000A2F98;
            11:      a = 34'h0000517CC;
            12:      a = 34'h000028BE6;
            13:      a = 34'h0000145F3;
            14:      a = 34'h00000A2F9;
            15:      a = 34'h00000517D;
            16:      a = 34'h0000028BE;
            17:      a = 34'h00000145F;
            18:      a = 34'h000000A30;
            19:      a = 34'h000000518;
            20:      a = 34'h00000028C;
            21:      a = 34'h000000146;
            22:      a = 34'h0000000A3;
            23:      a = 34'h000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/visibility_phase_rotator_core.sv
// Top level of the visibility phase rotator: stream ports, registers, pipeline.
// Rotates each visibility sample by -1000*path/wavelength turns (fraction only)
// and takes one item every clock cycle while the output is not stalled. It has
// five front stages for the path and numerator, one stage per quotient bit of
// the restoring divider (60 + PHASE_FRAC_BITS), two for the quadrant split, 24
// CORDIC stages and two for gain and saturation. The whole pipeline halts while
// a result waits at m_tdata. Registers: shift_back_enable at 0x00,
// uvw_sign_flip 0x04, rotate_bypass 0x08, offset_l 0x0C, offset_m 0x10;
// write them only while no item is in flight.
module visibility_phase_rotator_core #(
    parameter int SAMPLE_WIDTH    = 32,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // new_u, new_v, new_w, old_w, wavelength_um, sample_re, sample_im, pad
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rotated_re, rotated_im
    output logic [63:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int XW        = SAMPLE_WIDTH + 3;
    localparam int DIV_STEPS = vpr_pkg::AW + PHASE_FRAC_BITS;
    localparam int CI        = vpr_pkg::CORDIC_ITERS;

    logic r_shift_en, r_flip, r_byp;
    logic signed [31:0] r_off_l, r_off_m;
    logic en;

    vpr_pkg::t_side                 w_dv_side [0:DIV_STEPS];
    logic [vpr_pkg::AW-1:0]         w_dv_a    [0:DIV_STEPS];
    logic                           w_dv_neg  [0:DIV_STEPS];
    logic [vpr_pkg::DW-1:0]         w_dv_d    [0:DIV_STEPS];
    logic [vpr_pkg::DW-1:0]         w_dv_rem  [0:DIV_STEPS];
    logic [PHASE_FRAC_BITS-1:0]     w_dv_q    [0:DIV_STEPS];

    vpr_pkg::t_side                 w_cr_side [0:CI];
    logic signed [XW-1:0]           w_cr_x    [0:CI];
    logic signed [XW-1:0]           w_cr_y    [0:CI];
    logic signed [vpr_pkg::ZW-1:0]  w_cr_z    [0:CI];

    logic [31:0] w_re, w_im;

    assign pready   = 1'b1;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_en <= 1'b0;
            r_flip     <= 1'b0;
            r_byp      <= 1'b0;
            r_off_l    <= '0;
            r_off_m    <= '0;
        end else if (psel && penable && pwrite) begin
            case (vpr_pkg::t_reg'(paddr[4:2]))
                vpr_pkg::REG_SHIFT_BACK: r_shift_en <= pwdata[0];
                vpr_pkg::REG_SIGN_FLIP:  r_flip     <= pwdata[0];
                vpr_pkg::REG_BYPASS:     r_byp      <= pwdata[0];
                vpr_pkg::REG_OFFSET_L:   r_off_l    <= pwdata;
                vpr_pkg::REG_OFFSET_M:   r_off_m    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (vpr_pkg::t_reg'(paddr[4:2]))
            vpr_pkg::REG_SHIFT_BACK: prdata = {31'd0, r_shift_en};
            vpr_pkg::REG_SIGN_FLIP:  prdata = {31'd0, r_flip};
            vpr_pkg::REG_BYPASS:     prdata = {31'd0, r_byp};
            vpr_pkg::REG_OFFSET_L:   prdata = r_off_l;
            vpr_pkg::REG_OFFSET_M:   prdata = r_off_m;
            default:                 prdata = '0;
        endcase
    end

    vpr_path #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_path (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (s_tvalid),
        .i_u        (s_tdata[31:0]),
        .i_v        (s_tdata[63:32]),
        .i_w        (s_tdata[95:64]),
        .i_ow       (s_tdata[127:96]),
        .i_lam      (s_tdata[153:128]),
        .i_re       (s_tdata[185:154]),
        .i_im       (s_tdata[217:186]),
        .i_shift_en (r_shift_en),
        .i_flip     (r_flip),
        .i_byp      (r_byp),
        .i_off_l    (r_off_l),
        .i_off_m    (r_off_m),
        .o_side     (w_dv_side[0]),
        .o_a        (w_dv_a[0]),
        .o_neg      (w_dv_neg[0]),
        .o_d        (w_dv_d[0])
    );

    assign w_dv_rem[0] = '0;
    assign w_dv_q[0]   = '0;

    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
        vpr_div_step #(
            .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (w_dv_side[gi]),
            .i_a     (w_dv_a[gi]),
            .i_neg   (w_dv_neg[gi]),
            .i_d     (w_dv_d[gi]),
            .i_rem   (w_dv_rem[gi]),
            .i_q     (w_dv_q[gi]),
            .o_side  (w_dv_side[gi+1]),
            .o_a     (w_dv_a[gi+1]),
            .o_neg   (w_dv_neg[gi+1]),
            .o_d     (w_dv_d[gi+1]),
            .o_rem   (w_dv_rem[gi+1]),
            .o_q     (w_dv_q[gi+1])
        );
    end

    vpr_quad #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (w_dv_side[DIV_STEPS]),
        .i_neg   (w_dv_neg[DIV_STEPS]),
        .i_d     (w_dv_d[DIV_STEPS]),
        .i_rem   (w_dv_rem[DIV_STEPS]),
        .i_q     (w_dv_q[DIV_STEPS]),
        .o_side  (w_cr_side[0]),
        .o_x     (w_cr_x[0]),
        .o_y     (w_cr_y[0]),
        .o_z     (w_cr_z[0])
    );

    for (genvar gc = 0; gc < CI; gc++) begin : g_cordic
        vpr_cordic_step #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .ITER        (gc)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (w_cr_side[gc]),
            .i_x     (w_cr_x[gc]),
            .i_y     (w_cr_y[gc]),
            .i_z     (w_cr_z[gc]),
            .o_side  (w_cr_side[gc+1]),
            .o_x     (w_cr_x[gc+1]),
            .o_y     (w_cr_y[gc+1]),
            .o_z     (w_cr_z[gc+1])
        );
    end

    vpr_post #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (w_cr_side[CI]),
        .i_x     (w_cr_x[CI]),
        .i_y     (w_cr_y[CI]),
        .o_vld   (m_tvalid),
        .o_re    (w_re),
        .o_im    (w_im)
    );

    assign m_tdata = {w_im, w_re};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_side[DIV_STEPS].vld && (w_dv_d[DIV_STEPS] != '0)
        |-> (w_dv_rem[DIV_STEPS] < w_dv_d[DIV_STEPS]))
        else $error("divider remainder not below divisor");

    a_resid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cr_side[0].vld |-> (w_cr_z[0] >= -(64'sd1 <<< 29)) && (w_cr_z[0] < (64'sd1 <<< 29)))
        else $error("residual angle outside one eighth turn");
`endif

endmodule

FILE: rtl/vpr_path.sv
// Front stages: sign flip, path difference, offset products and phase numerator.
module vpr_path #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [31:0]         i_u,
    input  logic signed [31:0]         i_v,
    input  logic signed [31:0]         i_w,
    input  logic signed [31:0]         i_ow,
    input  logic [25:0]                i_lam,
    input  logic [31:0]                i_re,
    input  logic [31:0]                i_im,
    input  logic                       i_shift_en,
    input  logic                       i_flip,
    input  logic                       i_byp,
    input  logic signed [31:0]         i_off_l,
    input  logic signed [31:0]         i_off_m,
    output vpr_pkg::t_side             o_side,
    output logic [vpr_pkg::AW-1:0]     o_a,
    output logic                       o_neg,
    output logic [vpr_pkg::DW-1:0]     o_d
);

    vpr_pkg::t_side r_s1, r_s2, r_s3, r_s4, r_s5;
    vpr_pkg::t_side n_s1;
    logic signed [32:0] r_u1, r_v1, r_w1, n_u1, n_v1, n_w1;
    logic signed [31:0] r_ow1;
    logic [vpr_pkg::DW-1:0] r_d1, r_d2, r_d3, r_d4, r_d5;
    logic signed [64:0] r_pu2, r_pv2;
    logic signed [33:0] r_dw2;
    logic signed [vpr_pkg::PW-1:0] r_p3, n_p3;
    logic signed [vpr_pkg::MW-1:0] r_m4, n_m4;
    logic [vpr_pkg::AW-1:0] r_a5;
    logic r_neg5;

    always_comb begin
        n_u1 = 33'(i_u);
        n_v1 = 33'(i_v);
        n_w1 = 33'(i_w);
        if (i_flip) begin
            n_u1 = -n_u1;
            n_v1 = -n_v1;
            n_w1 = -n_w1;
        end
        n_s1.vld = i_vld;
        n_s1.byp = i_byp;
        n_s1.re  = 32'($signed(i_re[SAMPLE_WIDTH-1:0]));
        n_s1.im  = 32'($signed(i_im[SAMPLE_WIDTH-1:0]));
    end

    always_comb begin
        n_p3 = vpr_pkg::PW'(r_dw2) <<< 16;
        if (i_shift_en) begin
            n_p3 = n_p3 + vpr_pkg::PW'(r_pu2 >>> 14) + vpr_pkg::PW'(r_pv2 >>> 14);
        end
        // 1000 = 1024 - 16 - 8
        n_m4 = (vpr_pkg::MW'(r_p3) <<< 10) - (vpr_pkg::MW'(r_p3) <<< 4)
             - (vpr_pkg::MW'(r_p3) <<< 3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s5 <= r_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1   <= n_u1;
            r_v1   <= n_v1;
            r_w1   <= n_w1;
            r_ow1  <= i_ow;
            r_d1   <= {i_lam, 16'd0};
            r_pu2  <= r_u1 * i_off_l;
            r_pv2  <= r_v1 * i_off_m;
            r_dw2  <= 34'(r_w1) - 34'(r_ow1);
            r_d2   <= r_d1;
            r_p3   <= n_p3;
            r_d3   <= r_d2;
            r_m4   <= n_m4;
            r_d4   <= r_d3;
            // numerator is -1000 * path, so it is negative when the path is positive
            r_neg5 <= (r_m4 > 0);
            r_a5   <= vpr_pkg::AW'((r_m4 < 0) ? -r_m4 : r_m4);
            r_d5   <= r_d4;
        end
    end

    assign o_side = r_s5;
    assign o_a    = r_a5;
    assign o_neg  = r_neg5;
    assign o_d    = r_d5;

endmodule

FILE: rtl/vpr_div_step.sv
// One restoring division step of the phase divider.
module vpr_div_step #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  vpr_pkg::t_side               i_side,
    input  logic [vpr_pkg::AW-1:0]       i_a,
    input  logic                         i_neg,
    input  logic [vpr_pkg::DW-1:0]       i_d,
    input  logic [vpr_pkg::DW-1:0]       i_rem,
    input  logic [PHASE_FRAC_BITS-1:0]   i_q,
    output vpr_pkg::t_side               o_side,
    output logic [vpr_pkg::AW-1:0]       o_a,
    output logic                         o_neg,
    output logic [vpr_pkg::DW-1:0]       o_d,
    output logic [vpr_pkg::DW-1:0]       o_rem,
    output logic [PHASE_FRAC_BITS-1:0]   o_q
);

    vpr_pkg::t_side r_side;
    logic [vpr_pkg::AW-1:0] r_a;
    logic r_neg;
    logic [vpr_pkg::DW-1:0] r_d, r_rem, n_rem;
    logic [PHASE_FRAC_BITS-1:0] r_q;
    logic [vpr_pkg::DW:0] n_t;
    logic n_ge;

    always_comb begin
        n_t   = {i_rem, i_a[vpr_pkg::AW-1]};
        n_ge  = (n_t >= {1'b0, i_d});
        n_rem = n_ge ? vpr_pkg::DW'(n_t - {1'b0, i_d}) : vpr_pkg::DW'(n_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= i_a << 1;
            r_neg <= i_neg;
            r_d   <= i_d;
            r_rem <= n_rem;
            r_q   <= {i_q[PHASE_FRAC_BITS-2:0], n_ge};
        end
    end

    assign o_side = r_side;
    assign o_a    = r_a;
    assign o_neg  = r_neg;
    assign o_d    = r_d;
    assign o_rem  = r_rem;
    assign o_q    = r_q;

endmodule

FILE: rtl/vpr_quad.sv
// Phase fix-up, quadrant split and quarter-turn pre-rotation.
module vpr_quad #(
    parameter int SAMPLE_WIDTH    = 32,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  vpr_pkg::t_side                    i_side,
    input  logic                              i_neg,
    input  logic [vpr_pkg::DW-1:0]            i_d,
    input  logic [vpr_pkg::DW-1:0]            i_rem,
    input  logic [PHASE_FRAC_BITS-1:0]        i_q,
    output vpr_pkg::t_side                    o_side,
    output logic signed [SAMPLE_WIDTH+2:0]    o_x,
    output logic signed [SAMPLE_WIDTH+2:0]    o_y,
    output logic signed [vpr_pkg::ZW-1:0]     o_z
);

    localparam int XW = SAMPLE_WIDTH + 3;
    localparam int F  = PHASE_FRAC_BITS;

    vpr_pkg::t_side r_s1, r_s2;
    logic [F-1:0] r_q, n_q, n_t;
    logic signed [vpr_pkg::ZW-1:0] r_z, n_z, n_res;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y, n_re, n_im;
    vpr_pkg::t_quad n_k;

    always_comb begin
        // floored quotient of a negative numerator: -Q, or -Q-1 with a remainder
        if (i_d == '0) begin
            n_q = '0;
        end else if (i_neg) begin
            n_q = (i_rem != '0) ? ~i_q : -i_q;
        end else begin
            n_q = i_q;
        end
    end

    always_comb begin
        n_t   = r_q + (F'(1) << (F - 3));
        n_k   = vpr_pkg::t_quad'(n_t[F-1:F-2]);
        n_res = vpr_pkg::ZW'({1'b0, n_t[F-3:0]}) - (vpr_pkg::ZW'(1) << (F - 3));
        n_z   = n_res <<< (32 - F);
        n_re  = XW'(r_s1.re);
        n_im  = XW'(r_s1.im);
        case (n_k)
            vpr_pkg::QUAD_90: begin
                n_x = -n_im;
                n_y = n_re;
            end
            vpr_pkg::QUAD_180: begin
                n_x = -n_re;
                n_y = -n_im;
            end
            vpr_pkg::QUAD_270: begin
                n_x = n_im;
                n_y = -n_re;
            end
            default: begin
                n_x = n_re;
                n_y = n_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_en) begin
            r_s1 <= i_side;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_side = r_s2;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

FILE: rtl/vpr_cordic_step.sv
// One rotation-mode CORDIC iteration.
module vpr_cordic_step #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int ITER         = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  vpr_pkg::t_side                    i_side,
    input  logic signed [SAMPLE_WIDTH+2:0]    i_x,
    input  logic signed [SAMPLE_WIDTH+2:0]    i_y,
    input  logic signed [vpr_pkg::ZW-1:0]     i_z,
    output vpr_pkg::t_side                    o_side,
    output logic signed [SAMPLE_WIDTH+2:0]    o_x,
    output logic signed [SAMPLE_WIDTH+2:0]    o_y,
    output logic signed [vpr_pkg::ZW-1:0]     o_z
);

    vpr_pkg::t_side r_side;
    logic signed [SAMPLE_WIDTH+2:0] r_x, r_y, n_xs, n_ys;
    logic signed [vpr_pkg::ZW-1:0] r_z;

    assign n_xs = i_x >>> ITER;
    assign n_ys = i_y >>> ITER;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[vpr_pkg::ZW-1]) begin
                r_x <= i_x - n_ys;
                r_y <= i_y + n_xs;
                r_z <= i_z - vpr_pkg::atan_turn(ITER);
            end else begin
                r_x <= i_x + n_ys;
                r_y <= i_y - n_xs;
                r_z <= i_z + vpr_pkg::atan_turn(ITER);
            end
        end
    end

    assign o_side = r_side;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

FILE: rtl/vpr_post.sv
// Gain correction, rounding, saturation (or bypass of the sample) and the output register.
module vpr_post #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  vpr_pkg::t_side                    i_side,
    input  logic signed [SAMPLE_WIDTH+2:0]    i_x,
    input  logic signed [SAMPLE_WIDTH+2:0]    i_y,
    output logic                              o_vld,
    output logic [31:0]                       o_re,
    output logic [31:0]                       o_im
);

    localparam int XW = SAMPLE_WIDTH + 3;
    localparam int GW = XW + 31;

    vpr_pkg::t_side r_s1;
    logic r_vld;
    logic signed [GW-1:0] r_px, r_py;
    logic signed [31:0] r_re, r_im, n_re, n_im;

    function automatic logic signed [31:0] fin(input logic signed [GW-1:0] p);
        logic signed [GW-1:0] y;
        logic signed [GW-1:0] hi;
        logic signed [GW-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] s;
        y  = (p + (GW'(1) <<< 29)) >>> 30;
        hi = (GW'(1) <<< (SAMPLE_WIDTH - 1)) - GW'(1);
        lo = -hi - GW'(1);
        if (y > hi) begin
            s = SAMPLE_WIDTH'(hi);
        end else if (y < lo) begin
            s = SAMPLE_WIDTH'(lo);
        end else begin
            s = SAMPLE_WIDTH'(y);
        end
        return 32'(s);
    endfunction

    always_comb begin
        n_re = r_s1.byp ? r_s1.re : fin(r_px);
        n_im = r_s1.byp ? r_s1.im : fin(r_py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_s1  <= i_side;
            r_vld <= r_s1.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= i_x * $signed({1'b0, vpr_pkg::GAIN_Q30});
            r_py <= i_y * $signed({1'b0, vpr_pkg::GAIN_Q30});
            r_re <= n_re;
            r_im <= n_im;
        end
    end

    assign o_vld = r_vld;
    assign o_re  = r_re;
    assign o_im  = r_im;

endmodule

FILE: test/visibility_phase_rotator_core_tb.sv
// Self-checking testbench of the visibility phase rotator core.
`timescale 1ns / 1ps

module visibility_phase_rotator_core_tb;

    localparam int LATENCY = 109;
    localparam longint HOLD_CYCLES = 400;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // new_u, new_v, new_w, old_w, wavelength_um, sample_re, sample_im, pad
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // rotated_re, rotated_im
    logic [63:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // register shadows
    logic               cfg_shift_back = 1'b0;
    logic               cfg_sign_flip = 1'b0;
    logic               cfg_bypass = 1'b0;
    logic signed [31:0] cfg_offset_l = '0;
    logic signed [31:0] cfg_offset_m = '0;

    logic [63:0] rotated_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          phases_run = 0;
    bit          hold_req = 1'b0;
    bit          stall_on = 1'b1;

    longint turn_atan[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    visibility_phase_rotator_core dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic longint gain_sat(input longint a);
        longint b;
        b = (a * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
        if (b > 64'sd2147483647) b = 64'sd2147483647;
        if (b < -64'sd2147483648) b = -64'sd2147483648;
        return b;
    endfunction

    function automatic logic [63:0] rotate_sample(input logic [223:0] d);
        longint re, im, u, v, w, ow, p, n, dd, r, x, y, z, t, xs, ys, q, res;
        re = $signed(d[185:154]);
        im = $signed(d[217:186]);
        if (cfg_bypass) return {im[31:0], re[31:0]};
        u = $signed(d[31:0]);
        v = $signed(d[63:32]);
        w = $signed(d[95:64]);
        ow = $signed(d[127:96]);
        if (cfg_sign_flip) begin
            u = -u; v = -v; w = -w;
        end
        p = (w - ow) * 65536;
        if (cfg_shift_back) begin
            p += (u * longint'(cfg_offset_l)) >>> 14;
            p += (v * longint'(cfg_offset_m)) >>> 14;
        end
        q = 0;
        if (d[153:128] != 0) begin
            n = -1000 * p;
            dd = longint'({d[153:128], 16'h0});
            r = n % dd;
            if (r < 0) r += dd;
            for (int i = 0; i < 16; i++) begin
                r = r * 2;
                q = q << 1;
                if (r >= dd) begin
                    r -= dd; q |= 1;
                end
            end
        end
        res = ((q + 8192) & 16383) - 8192;
        z = res * 65536;
        case (vpr_pkg::t_quad'(((q + 8192) >> 14) & 3))
            vpr_pkg::QUAD_90:  begin x = -im; y = re;  end
            vpr_pkg::QUAD_180: begin x = -re; y = -im; end
            vpr_pkg::QUAD_270: begin x = im;  y = -re; end
            default:           begin x = re;  y = im;  end
        endcase
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys; y = y + xs; x = t; z -= turn_atan[i];
            end else begin
                t = x + ys; y = y - xs; x = t; z += turn_atan[i];
            end
        end
        x = gain_sat(x);
        y = gain_sat(y);
        return {y[31:0], x[31:0]};
    endfunction

    task automatic reg_write(input vpr_pkg::t_reg idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            vpr_pkg::REG_SHIFT_BACK: cfg_shift_back = val[0];
            vpr_pkg::REG_SIGN_FLIP:  cfg_sign_flip = val[0];
            vpr_pkg::REG_BYPASS:     cfg_bypass = val[0];
            vpr_pkg::REG_OFFSET_L:   cfg_offset_l = val;
            vpr_pkg::REG_OFFSET_M:   cfg_offset_m = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input bit sb, input bit fl, input bit by,
                              input logic [31:0] l, input logic [31:0] m);
        reg_write(vpr_pkg::REG_SHIFT_BACK, {31'h0, sb});
        reg_write(vpr_pkg::REG_SIGN_FLIP, {31'h0, fl});
        reg_write(vpr_pkg::REG_BYPASS, {31'h0, by});
        reg_write(vpr_pkg::REG_OFFSET_L, l);
        reg_write(vpr_pkg::REG_OFFSET_M, m);
        phases_run++;
    endtask

    // drop the offer, wait for every result, then let the pipeline empty out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(input logic [31:0] u, v, w, ow, input logic [25:0] lam,
                             input logic [31:0] re, im, input int gap);
        s_tvalid <= 1'b1;
        s_tdata <= {6'h0, im, re, lam, ow, w, v, u};
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        rotated_q.push_back(rotate_sample({6'h0, im, re, lam, ow, w, v, u}));
        items_sent++;
        @(posedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int rand_gap();
        int s;
        s = $urandom_range(0, 99);
        if (s < 60) return 0;
        if (s < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [25:0] rand_lambda();
        case ($urandom_range(0, 3))
            0: return 26'($urandom_range(1, 1000));
            1: return 26'($urandom_range(1, 1000000));
            default: return 26'($urandom);
        endcase
    endfunction

    task automatic send_random(input int gap);
        send_item($urandom, $urandom, $urandom, $urandom, rand_lambda(),
                  $urandom, $urandom, gap);
    endtask

    task automatic test_defaults();
        send_item(32'd1000, 32'd0, 32'd500, 32'd0, 26'd1, 32'd1000000, 32'd0, 0);
        send_item(32'h7FFFFFFF, 32'h80000001, 32'h7FFFFFFF, 32'h80000001, 26'h3FFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_item(32'h80000001, 32'h7FFFFFFF, 32'h80000001, 32'h7FFFFFFF, 26'd1,
                  32'h80000000, 32'h80000000, 1);
        // zero wavelength: no phase, still goes through the CORDIC
        send_item(32'd12345, 32'd6789, 32'd555, 32'd111, 26'd0,
                  32'h7FFFFFFF, 32'h80000000, 0);
        send_item(32'd0, 32'd0, 32'd250, 32'd0, 26'd1000, 32'h40000000, 32'hC0000000, 0);
        send_item(32'd0, 32'd0, 32'd0, 32'd0, 26'd1, 32'd0, 32'd0, 2);
        send_item(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 32'd1, 26'd3, 32'h80000000,
                  32'h7FFFFFFF, 0);
        drain();
    endtask

    task automatic test_shift_back();
        set_config(1'b1, 1'b1, 1'b0, 32'h40000000, 32'hC0000000);
        // negating the most negative coordinate
        send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 26'd7,
                  32'h12345678, 32'h9ABCDEF0, 0);
        send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd3, 32'd1, 26'h3FFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 0);
        send_item(32'd123456, 32'hFFF00000, 32'd0, 32'd0, 26'd21000,
                  32'h01000000, 32'h02000000, 0);
        drain();
        set_config(1'b1, 1'b0, 1'b0, 32'hC0000000, 32'h40000000);
        send_item(32'h80000000, 32'h7FFFFFFF, 32'd9, 32'd9, 26'd1,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_item(32'd5000000, 32'd4000000, 32'd100, 32'd50, 26'd210000,
                  32'hFFFF0000, 32'h0000FFFF, 0);
        // unknown register index must leave the settings alone
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 5'h1C; pwdata <= 32'hFFFFFFFF;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        send_item(32'd77, 32'd88, 32'd99, 32'd11, 26'd500, 32'd1000, 32'd2000, 0);
        drain();
    endtask

    task automatic test_bypass();
        set_config(1'b1, 1'b1, 1'b1, 32'h40000000, 32'h40000000);
        send_item(32'h80000000, 32'h7FFFFFFF, 32'd5, 32'd6, 26'd0,
                  32'h80000000, 32'h7FFFFFFF, 0);
        send_item(32'd1, 32'd2, 32'd3, 32'd4, 26'd5, 32'hDEADBEEF, 32'h01234567, 0);
        drain();
    endtask

    task automatic test_stall_fill();
        set_config(1'b0, 1'b0, 1'b0, 32'h0, 32'h0);
        hold_req = 1'b1;
        repeat (250) send_random(0);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            logic [31:0] l, m;
            l = (ph == 1) ? 32'h40000000 : (ph == 2) ? 32'hC0000000
                : 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
            m = (ph == 1) ? 32'hC0000000 : (ph == 2) ? 32'h40000000
                : 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
            set_config($urandom_range(0, 1), $urandom_range(0, 1),
                       (ph % 4 == 3), l, m);
            stall_on = (ph != 5);
            for (int n = 0; n < 140; n++)
                send_random(stall_on ? rand_gap() : 0);
            drain();
        end
        stall_on = 1'b1;
    endtask

    // result side: random stalls, one long hold-off, field checks
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (longint c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (stall_on && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
            @(negedge i_clk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (rotated_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result re=%h im=%h", m_tdata[31:0], m_tdata[63:32]);
                end else begin
                    logic [63:0] want;
                    want = rotated_q.pop_front();
                    if (want[31:0] !== m_tdata[31:0] || want[63:32] !== m_tdata[63:32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: re exp %h got %h, im exp %h got %h",
                                     results_seen, want[31:0], m_tdata[31:0],
                                     want[63:32], m_tdata[63:32]);
                    end
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("timeout waiting on results");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_shift_back();
        test_bypass();
        test_stall_fill();
        test_random();
        drain();
        if (rotated_q.size() != 0) mismatches += rotated_q.size();
        $display("%0d samples rotated over %0d register settings, %0d results checked",
                 items_sent, phases_run + 1, results_seen);
        $display("covered bypass, shift-back, sign flip, zero wavelength, full-pipe stall");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/vpr_pkg.sv
rtl/vpr_path.sv
rtl/vpr_div_step.sv
rtl/vpr_quad.sv
rtl/vpr_cordic_step.sv
rtl/vpr_post.sv
rtl/visibility_phase_rotator_core.sv
test/visibility_phase_rotator_core_tb.sv
